/* rtl/paa_pkg.sv */
// Shared types and constants of the paged arena allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package paa_pkg;

  // Fixed widths of the word fields.
  localparam int MODE_W   = 2;
  localparam int SIZE_W   = 16;
  localparam int ALIGN_W  = 4;
  localparam int ADDR_W   = 20;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 5;
  localparam int FIT_W    = SIZE_W + 1;

  // Reset value of the usable page size register.
  localparam logic [SIZE_W-1:0] PAGE_BYTES_RESET = 16'd4096;

  // Operation codes of an input word.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC      = 2'd0,
    MODE_REALLOC    = 2'd1,
    MODE_RESET_ALL  = 2'd2,
    MODE_RESET_MARK = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_PAGES  = 2'd2,
    ST_NO_MARK   = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic walk_init;
    logic walk_next;
    logic align;
    logic check;
    logic place;
    logic open_page;
    logic fail_large;
    logic fail_full;
    logic inplace;
    logic clear_init;
    logic clear_step;
    logic mark;
    logic out_load;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  too_large;
    logic  inplace_ok;
    logic  walk_any;
    logic  pages_full;
    logic  fit;
    logic  more;
    logic  clear_more;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/paa_if.sv */
// Valid/ready channel interfaces for the request and result words.
// Depends on paa_pkg for the field widths.
`default_nettype none

interface paa_req_if;
  logic                           valid;
  logic                           ready;
  logic [paa_pkg::MODE_W-1:0]     mode;
  logic [paa_pkg::SIZE_W-1:0]     request_size;
  logic [paa_pkg::ALIGN_W-1:0]    align_log2;
  logic [paa_pkg::ADDR_W-1:0]     address;
  logic                           old_valid;
  logic [paa_pkg::SIZE_W-1:0]     old_size;

  modport source (
    output valid, mode, request_size, align_log2, address, old_valid, old_size,
    input  ready
  );
  modport sink (
    input  valid, mode, request_size, align_log2, address, old_valid, old_size,
    output ready
  );
endinterface

interface paa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [paa_pkg::STATUS_W-1:0]   status;
  logic [paa_pkg::ADDR_W-1:0]     block_address;
  logic                           copy_needed;
  logic [paa_pkg::SIZE_W-1:0]     copy_bytes;
  logic [paa_pkg::USED_W-1:0]     pages_used;

  modport source (
    output valid, status, block_address, copy_needed, copy_bytes, pages_used,
    input  ready
  );
  modport sink (
    input  valid, status, block_address, copy_needed, copy_bytes, pages_used,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/paa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module paa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/paa_ctrl.sv */
// Controller state machine of the paged arena allocator.
// Depends on paa_pkg for the command and status structs and the mode codes.
`default_nettype none

module paa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire paa_pkg::stat_t stat,
  output paa_pkg::cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_FETCH  = 7'b0000100,
    S_ALIGN  = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.mode) inside
          paa_pkg::MODE_ALLOC, paa_pkg::MODE_REALLOC: begin
            if (stat.mode == paa_pkg::MODE_REALLOC && stat.inplace_ok) begin
              cmd.inplace = 1'b1;
              state_nxt   = S_FINISH;
            end else if (stat.too_large) begin
              cmd.fail_large = 1'b1;
              state_nxt      = S_FINISH;
            end else if (stat.walk_any) begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_FETCH;
            end else if (stat.pages_full) begin
              cmd.fail_full = 1'b1;
              state_nxt     = S_FINISH;
            end else begin
              cmd.open_page = 1'b1;
              state_nxt     = S_FINISH;
            end
          end
          paa_pkg::MODE_RESET_ALL: begin
            cmd.clear_init = 1'b1;
            state_nxt      = S_CLEAR;
          end
          paa_pkg::MODE_RESET_MARK: begin
            cmd.mark  = 1'b1;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FETCH: begin
        state_nxt = S_ALIGN;
      end
      S_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.fit) begin
          cmd.place = 1'b1;
          state_nxt = S_FINISH;
        end else if (stat.more) begin
          cmd.walk_next = 1'b1;
          state_nxt     = S_FETCH;
        end else if (stat.pages_full) begin
          cmd.fail_full = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          cmd.open_page = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_CLEAR: begin
        if (stat.clear_more) begin
          cmd.clear_step = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result register is full from its load until the word is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while full");

  // An accepted word always goes straight to the decision step.
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECIDE))
    else $error("accepted word did not reach the decision step");

  // A page check either walks on or ends the item.
  a_check_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |=> (state_r == S_FETCH || state_r == S_FINISH))
    else $error("unexpected state after a page check");

endmodule

`default_nettype wire

/* rtl/paa_dp.sv */
// Datapath of the paged arena allocator: item and result registers, page state,
// fit arithmetic and the page fill RAM. Depends on paa_pkg and paa_ram.
`default_nettype none

module paa_dp #(
  parameter int MAX_PAGES        = 16,
  parameter int PAGE_STRIDE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire paa_pkg::cmd_t                  cmd,
  output paa_pkg::stat_t                      stat,
  input  wire logic                           cfg_we,
  input  wire logic [paa_pkg::SIZE_W-1:0]     cfg_wdata,
  input  wire logic [paa_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [paa_pkg::SIZE_W-1:0]     in_request_size,
  input  wire logic [paa_pkg::ALIGN_W-1:0]    in_align_log2,
  input  wire logic [paa_pkg::ADDR_W-1:0]     in_address,
  input  wire logic                           in_old_valid,
  input  wire logic [paa_pkg::SIZE_W-1:0]     in_old_size,
  output logic      [paa_pkg::STATUS_W-1:0]   out_status,
  output logic      [paa_pkg::ADDR_W-1:0]     out_block_address,
  output logic                                out_copy_needed,
  output logic      [paa_pkg::SIZE_W-1:0]     out_copy_bytes,
  output logic      [paa_pkg::USED_W-1:0]     out_pages_used
);

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int OW = $clog2(MAX_PAGES + 1);
  localparam int MW = PW + PAGE_STRIDE_BITS + paa_pkg::ADDR_W;
  localparam int AW = paa_pkg::ADDR_W;
  localparam int SW = paa_pkg::SIZE_W;
  localparam int FW = paa_pkg::FIT_W;
  localparam logic [AW-1:0] OFF_MASK = AW'((64'd1 << PAGE_STRIDE_BITS) - 64'd1);

  // Held item fields.
  logic [paa_pkg::MODE_W-1:0]  mode_r;
  logic [SW-1:0]               req_r;
  logic [paa_pkg::ALIGN_W-1:0] align_r;
  logic [AW-1:0]               addr_r;
  logic                        old_valid_r;
  logic [SW-1:0]               old_size_r;

  // Allocator state.
  logic [SW-1:0]  page_bytes_r;
  logic [OW-1:0]  pages_open_r;
  logic [PW-1:0]  cur_r;
  logic [AW-1:0]  last_block_r;
  logic           lbv_r;
  logic [OW-1:0]  idx_r;
  logic [FW-1:0]  aligned_r;

  // Result being built and the output register.
  paa_pkg::status_t  res_status_r;
  logic [AW-1:0]     res_addr_r;
  logic              res_copy_r;
  logic [SW-1:0]     res_cbytes_r;
  paa_pkg::status_t  out_status_r;
  logic [AW-1:0]     out_addr_r;
  logic              out_copy_r;
  logic [SW-1:0]     out_cbytes_r;
  logic [paa_pkg::USED_W-1:0] out_pages_r;

  // Combinational values.
  logic            cur_lt_open;
  logic            pages_full;
  logic [AW-1:0]   off_full;
  logic [AW-1:0]   pg_full;
  logic            off_le_pb;
  logic [AW:0]     off_plus_req;
  logic            mark_ok;
  logic [FW-1:0]   amask;
  logic [FW-1:0]   aligned_nxt;
  logic [FW-1:0]   fill_fit;
  logic [OW-1:0]   idx_inc;
  logic [PW-1:0]   new_pg;
  logic [PW-1:0]   commit_pg;
  logic [SW-1:0]   commit_off;
  logic [AW-1:0]   commit_addr;
  logic [SW-1:0]   copy_min;
  logic            is_realloc;
  logic            ram_we;
  logic [PW-1:0]   ram_waddr;
  logic [SW-1:0]   ram_wdata;
  logic [SW-1:0]   ram_rdata;

  // Page index shifted into place plus the offset, kept to the address width.
  function automatic logic [AW-1:0] make_addr(input logic [PW-1:0] pg,
                                              input logic [SW-1:0] off);
    logic [MW-1:0] wide;
    wide = (MW'(pg) << PAGE_STRIDE_BITS) + MW'(off);
    return wide[AW-1:0];
  endfunction

  // Decisions on the held word and the page state.
  assign cur_lt_open  = OW'(cur_r) < pages_open_r;
  assign pages_full   = pages_open_r >= OW'(MAX_PAGES);
  assign off_full     = addr_r & OFF_MASK;
  assign pg_full      = addr_r >> PAGE_STRIDE_BITS;
  assign off_le_pb    = off_full <= AW'(page_bytes_r);
  assign off_plus_req = (AW + 1)'(off_full) + (AW + 1)'(req_r);
  assign mark_ok      = (pages_open_r != '0) && cur_lt_open &&
                        (pg_full <= AW'(cur_r)) && off_le_pb;
  assign is_realloc   = (paa_pkg::mode_t'(mode_r) == paa_pkg::MODE_REALLOC);

  // Alignment of a page fill and the fit test on the aligned offset.
  assign amask       = FW'((FW'(1) << align_r) - FW'(1));
  assign aligned_nxt = (FW'(ram_rdata) + amask) & ~amask;
  assign fill_fit    = aligned_r + FW'(req_r);

  assign idx_inc  = idx_r + OW'(1);
  assign new_pg   = pages_open_r[PW-1:0];
  assign copy_min = (old_size_r < req_r) ? old_size_r : req_r;

  // A successful allocation lands either in the walked page or a new one.
  assign commit_pg   = cmd.open_page ? new_pg : idx_r[PW-1:0];
  assign commit_off  = cmd.open_page ? '0 : aligned_r[SW-1:0];
  assign commit_addr = make_addr(commit_pg, commit_off);

  always_comb begin
    stat.mode       = paa_pkg::mode_t'(mode_r);
    stat.too_large  = req_r > page_bytes_r;
    stat.inplace_ok = old_valid_r && lbv_r && (addr_r == last_block_r) &&
                      cur_lt_open && off_le_pb &&
                      (off_plus_req <= (AW + 1)'(page_bytes_r));
    stat.walk_any   = cur_lt_open;
    stat.pages_full = pages_full;
    stat.fit        = (aligned_r <= FW'(page_bytes_r)) &&
                      ((FW + 1)'(aligned_r) + (FW + 1)'(req_r) <= (FW + 1)'(page_bytes_r));
    stat.more       = idx_inc < pages_open_r;
    stat.clear_more = idx_r < pages_open_r;
  end

  // Page fill write port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = '0;
    if (cmd.inplace) begin
      ram_we    = 1'b1;
      ram_waddr = cur_r;
      ram_wdata = off_plus_req[SW-1:0];
    end
    if (cmd.place) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r[PW-1:0];
      ram_wdata = fill_fit[SW-1:0];
    end
    if (cmd.open_page) begin
      ram_we    = 1'b1;
      ram_waddr = new_pg;
      ram_wdata = req_r;
    end
    if (cmd.mark && mark_ok) begin
      ram_we    = 1'b1;
      ram_waddr = pg_full[PW-1:0];
      ram_wdata = off_full[SW-1:0];
    end
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r[PW-1:0];
      ram_wdata = '0;
    end
  end

  paa_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_PAGES)
  ) u_fill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[PW-1:0]),
    .rdata (ram_rdata)
  );

  // Allocator control state and the page size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r <= paa_pkg::PAGE_BYTES_RESET;
      pages_open_r <= '0;
      cur_r        <= '0;
      last_block_r <= '0;
      lbv_r        <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (cfg_we) begin
        page_bytes_r <= cfg_wdata;
      end
      if (cmd.walk_init) begin
        idx_r <= OW'(cur_r);
      end
      if (cmd.walk_next || cmd.clear_step) begin
        idx_r <= idx_inc;
      end
      if (cmd.clear_init) begin
        idx_r <= '0;
        cur_r <= '0;
        lbv_r <= 1'b0;
      end
      if (cmd.check) begin
        cur_r <= idx_r[PW-1:0];
      end
      if (cmd.place || cmd.open_page) begin
        last_block_r <= commit_addr;
        lbv_r        <= 1'b1;
      end
      if (cmd.open_page) begin
        pages_open_r <= pages_open_r + OW'(1);
        cur_r        <= new_pg;
      end
      if (cmd.mark) begin
        lbv_r <= 1'b0;
        if (mark_ok) begin
          cur_r <= pg_full[PW-1:0];
        end
      end
    end
  end

  // Item, fit and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r       <= in_mode;
      req_r        <= in_request_size;
      align_r      <= in_align_log2;
      addr_r       <= in_address;
      old_valid_r  <= in_old_valid;
      old_size_r   <= in_old_size;
      res_status_r <= paa_pkg::ST_OK;
      res_addr_r   <= '0;
      res_copy_r   <= 1'b0;
      res_cbytes_r <= '0;
    end
    if (cmd.align) begin
      aligned_r <= aligned_nxt;
    end
    if (cmd.inplace) begin
      res_addr_r <= addr_r;
    end
    if (cmd.place || cmd.open_page) begin
      res_addr_r <= commit_addr;
      if (is_realloc && old_valid_r) begin
        res_copy_r   <= 1'b1;
        res_cbytes_r <= copy_min;
      end
    end
    if (cmd.fail_large) begin
      res_status_r <= paa_pkg::ST_TOO_LARGE;
    end
    if (cmd.fail_full) begin
      res_status_r <= paa_pkg::ST_NO_PAGES;
    end
    if (cmd.mark) begin
      if (mark_ok) begin
        res_addr_r <= addr_r;
      end else begin
        res_status_r <= paa_pkg::ST_NO_MARK;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_copy_r   <= res_copy_r;
      out_cbytes_r <= res_cbytes_r;
      out_pages_r  <= paa_pkg::USED_W'(pages_open_r);
    end
  end

  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_copy_needed   = out_copy_r;
  assign out_copy_bytes    = out_cbytes_r;
  assign out_pages_used    = out_pages_r;

  // The slot count never passes the number of slots.
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pages_open_r <= OW'(MAX_PAGES))
    else $error("more pages open than slots");

  // The current page is always an open page once any page is open.
  a_cur_open: assert property (@(posedge clk) disable iff (!rst_n)
    (pages_open_r != '0) |-> cur_lt_open)
    else $error("current page beyond the open pages");

  // A new page is only opened while a slot is free.
  a_open_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.open_page |-> !pages_full)
    else $error("page opened with all slots in use");

endmodule

`default_nettype wire

/* rtl/paged_arena_allocator.sv */
// Top level of the paged arena allocator: controller, datapath and channel wiring.
// Depends on paa_pkg, paa_if, paa_ctrl and paa_dp.
//
//   Port     Direction  Handshake      Word
//   in_req   in         valid/ready    mode, request_size, align_log2, address,
//                                      old_valid, old_size
//   out_rsp  out        valid/ready    status, block_address, copy_needed,
//                                      copy_bytes, pages_used
//   cfg_*    in         write enable   page_bytes (16 bits)
//
// An item goes from acceptance through the decision step to the result load. An allocation
// adds a fill read, an alignment and a fit check for each page that it walks, and a full
// reset adds a pass that clears the fills of the open pages one per cycle.
// One item is in work at a time; the next one is accepted while the result still
// waits in the output register, and a result that is not taken holds the next one.
// Reset is synchronous and active low; the page fill RAM needs no clearing pass.
`default_nettype none

module paged_arena_allocator #(
  parameter int MAX_PAGES        = 16,
  parameter int PAGE_STRIDE_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  paa_req_if.sink                         in_req,
  paa_rsp_if.source                       out_rsp,
  input  wire logic                       cfg_we,
  input  wire logic [paa_pkg::SIZE_W-1:0] cfg_wdata
);

  paa_pkg::cmd_t  cmd;
  paa_pkg::stat_t stat;

  // Sequencing of each item.
  paa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Page state, arithmetic and result registers.
  paa_dp #(
    .MAX_PAGES        (MAX_PAGES),
    .PAGE_STRIDE_BITS (PAGE_STRIDE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_req.mode),
    .in_request_size   (in_req.request_size),
    .in_align_log2     (in_req.align_log2),
    .in_address        (in_req.address),
    .in_old_valid      (in_req.old_valid),
    .in_old_size       (in_req.old_size),
    .out_status        (out_rsp.status),
    .out_block_address (out_rsp.block_address),
    .out_copy_needed   (out_rsp.copy_needed),
    .out_copy_bytes    (out_rsp.copy_bytes),
    .out_pages_used    (out_rsp.pages_used)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of the paged arena allocator: directed words, then random phases.
// Depends on paa_pkg, the paa_req_if/paa_rsp_if channels and the paged_arena_allocator top.
// Results are checked against typed row results or a behavioral arena model in this file.
`default_nettype none

module tb;
  import paa_pkg::*;

  localparam int MAX_PAGES   = 16;
  localparam int STRIDE_BITS = 16;
  localparam int HIST_DEPTH  = 16;
  localparam int PHASE_N     = 9;
  localparam int PHASE_WORDS = 150;
  localparam int RAND_PHASE  = 6;
  localparam int PRESS_PHASE = 7;
  localparam int PRESS_HOLD  = 200;
  localparam int DRAIN_WAIT  = 100;
  localparam int DIR_N       = 24;

  // One request word and one result word as the testbench sees them.
  typedef struct packed {
    mode_t       mode;
    logic [15:0] size;
    logic [3:0]  align;
    logic [19:0] addr;
    logic        oldv;
    logic [15:0] olds;
  } arena_req_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] baddr;
    logic        copy;
    logic [15:0] cbytes;
    logic [4:0]  used;
  } arena_rsp_t;

  // A directed row: the word, how often it is sent, and an optional typed result.
  typedef struct packed {
    arena_req_t req;
    logic [4:0] reps;
    logic       typed;
    arena_rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  paa_req_if req_ch ();
  paa_rsp_if rsp_ch ();

  paged_arena_allocator #(
    .MAX_PAGES       (MAX_PAGES),
    .PAGE_STRIDE_BITS(STRIDE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_rsp  (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Arena model state.
  logic [15:0] arena_fill [MAX_PAGES];
  logic [4:0]  open_cnt;
  logic [3:0]  cur_pg;
  logic [19:0] last_addr;
  logic        last_ok;
  logic [15:0] pb_reg;

  arena_rsp_t  rsp_q [$];
  logic [19:0] granted_q [$];
  int          err_cnt;
  bit          hold_req;
  bit          quiet;

  // Directed words; page_bytes is at its reset value of 4096 throughout.
  dir_row_t dir_tab [DIR_N] = '{
    '{'{MODE_ALLOC,      16'd0,     4'd0,  20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h00000, 1'b0, 16'd0,  5'd1}},
    '{'{MODE_ALLOC,      16'd100,   4'd0,  20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h00000, 1'b0, 16'd0,  5'd1}},
    '{'{MODE_ALLOC,      16'd4097,  4'd0,  20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_TOO_LARGE, 20'h00000, 1'b0, 16'd0,  5'd1}},
    '{'{MODE_ALLOC,      16'd65535, 4'd15, 20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_TOO_LARGE, 20'h00000, 1'b0, 16'd0,  5'd1}},
    '{'{MODE_ALLOC,      16'd10,    4'd4,  20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h00070, 1'b0, 16'd0,  5'd1}},
    '{'{MODE_REALLOC,    16'd50,    4'd0,  20'h00070, 1'b1, 16'd10},    5'd1, 1'b1,
      '{ST_OK,        20'h00070, 1'b0, 16'd0,  5'd1}},
    '{'{MODE_REALLOC,    16'd5000,  4'd0,  20'h00070, 1'b1, 16'd10},    5'd1, 1'b1,
      '{ST_TOO_LARGE, 20'h00000, 1'b0, 16'd0,  5'd1}},
    '{'{MODE_REALLOC,    16'd4000,  4'd0,  20'h00070, 1'b1, 16'd40},    5'd1, 1'b1,
      '{ST_OK,        20'h10000, 1'b1, 16'd40, 5'd2}},
    '{'{MODE_REALLOC,    16'd8,     4'd3,  20'hFFFFF, 1'b0, 16'd65535}, 5'd1, 1'b1,
      '{ST_OK,        20'h10FA0, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_RESET_MARK, 16'd0,     4'd0,  20'h00070, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h00070, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_RESET_MARK, 16'd0,     4'd0,  20'h30000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_NO_MARK,   20'h00000, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_RESET_MARK, 16'd0,     4'd0,  20'h01001, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_NO_MARK,   20'h00000, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_REALLOC,    16'd16,    4'd0,  20'h00070, 1'b1, 16'd65535}, 5'd1, 1'b1,
      '{ST_OK,        20'h00070, 1'b1, 16'd16, 5'd2}},
    '{'{MODE_RESET_ALL,  16'd65535, 4'd15, 20'hFFFFF, 1'b1, 16'd65535}, 5'd1, 1'b1,
      '{ST_OK,        20'h00000, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_RESET_MARK, 16'd0,     4'd0,  20'h01000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h01000, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_ALLOC,      16'd0,     4'd0,  20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h01000, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_ALLOC,      16'd1,     4'd0,  20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h10000, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_REALLOC,    16'd4096,  4'd0,  20'h10000, 1'b1, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h10000, 1'b0, 16'd0,  5'd2}},
    '{'{MODE_ALLOC,      16'd4096,  4'd0,  20'h00000, 1'b0, 16'd0},     5'd14, 1'b0,
      '{ST_OK,        20'h00000, 1'b0, 16'd0,  5'd0}},
    '{'{MODE_ALLOC,      16'd4096,  4'd12, 20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_NO_PAGES,  20'h00000, 1'b0, 16'd0,  5'd16}},
    '{'{MODE_REALLOC,    16'd200,   4'd0,  20'hF0000, 1'b1, 16'd300},   5'd1, 1'b1,
      '{ST_OK,        20'hF0000, 1'b0, 16'd0,  5'd16}},
    '{'{MODE_REALLOC,    16'd4000,  4'd2,  20'h12345, 1'b1, 16'd300},   5'd1, 1'b1,
      '{ST_NO_PAGES,  20'h00000, 1'b0, 16'd0,  5'd16}},
    '{'{MODE_RESET_MARK, 16'd0,     4'd0,  20'hFFFFF, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_NO_MARK,   20'h00000, 1'b0, 16'd0,  5'd16}},
    '{'{MODE_RESET_ALL,  16'd0,     4'd0,  20'h00000, 1'b0, 16'd0},     5'd1, 1'b1,
      '{ST_OK,        20'h00000, 1'b0, 16'd0,  5'd16}}
  };

  localparam logic [15:0] PHASE_PB [PHASE_N] = '{
    16'd65535, 16'd0, 16'd1, 16'd37, 16'd256, 16'd4096, 16'd4096, 16'd64, 16'd1000
  };

  // Place size bytes in page p at the aligned fill offset, if it fits.
  function automatic bit place_in_page(input int unsigned p, input int unsigned size,
                                       input int unsigned alg, output int unsigned off);
    int unsigned a;
    int unsigned aligned;
    int unsigned pb;
    pb = pb_reg;
    a = 32'd1 << (alg & 15);
    aligned = (int'(arena_fill[p]) + a - 1) & ~(a - 1);
    off = aligned;
    if (aligned > pb || size > pb - aligned) return 1'b0;
    arena_fill[p] = 16'(aligned + size);
    return 1'b1;
  endfunction

  // Walk the open pages from the current one, opening a new page when none fits.
  function automatic status_t arena_alloc(input int unsigned size, input int unsigned alg,
                                          output logic [19:0] addr);
    int unsigned p;
    int unsigned off;
    addr = '0;
    if (size > int'(pb_reg)) return ST_TOO_LARGE;
    for (p = cur_pg; p < open_cnt; p++) begin
      cur_pg = p[3:0];
      if (place_in_page(p, size, alg, off)) begin
        addr = 20'((p << STRIDE_BITS) + off);
        last_addr = addr;
        last_ok = 1'b1;
        return ST_OK;
      end
    end
    if (open_cnt >= MAX_PAGES) return ST_NO_PAGES;
    p = open_cnt;
    open_cnt = open_cnt + 5'd1;
    arena_fill[p] = '0;
    cur_pg = p[3:0];
    if (!place_in_page(p, size, alg, off)) return ST_TOO_LARGE;
    addr = 20'((p << STRIDE_BITS) + off);
    last_addr = addr;
    last_ok = 1'b1;
    return ST_OK;
  endfunction

  // Apply one accepted request word to the arena model and return its result word.
  function automatic arena_rsp_t arena_step(input arena_req_t r);
    arena_rsp_t o;
    int unsigned off;
    int unsigned pg;
    int unsigned pb;
    int unsigned p;
    logic [19:0] a;
    o = '0;
    a = '0;
    pb = pb_reg;
    off = r.addr[15:0];
    pg = r.addr[19:16];
    case (r.mode)
      MODE_ALLOC: begin
        o.status = arena_alloc(r.size, r.align, a);
        o.baddr = a;
      end
      MODE_REALLOC: begin
        if (r.oldv && last_ok && r.addr == last_addr && cur_pg < open_cnt &&
            off <= pb && pb - off >= r.size) begin
          // Grow or shrink the last block where it stands.
          arena_fill[cur_pg] = 16'(off + r.size);
          o.baddr = r.addr;
        end else begin
          o.status = arena_alloc(r.size, r.align, a);
          o.baddr = a;
          if (o.status == ST_OK && r.oldv) begin
            o.copy = 1'b1;
            o.cbytes = (r.olds < r.size) ? r.olds : r.size;
          end
        end
      end
      MODE_RESET_ALL: begin
        for (p = 0; p < open_cnt && p < MAX_PAGES; p++) arena_fill[p] = '0;
        cur_pg = '0;
        last_ok = 1'b0;
      end
      default: begin
        // Reset to a mark in the current page or one below it.
        last_ok = 1'b0;
        if (open_cnt > 0 && cur_pg < open_cnt && pg <= cur_pg && off <= pb) begin
          arena_fill[pg] = 16'(off);
          cur_pg = pg[3:0];
          o.baddr = r.addr;
        end else begin
          o.status = ST_NO_MARK;
        end
      end
    endcase
    if (o.status != ST_OK) o.baddr = '0;
    o.used = open_cnt;
    return o;
  endfunction

  // Sizes are mostly small, up to an eighth of the page size, with some near or just beyond it and some noise.
  function automatic logic [15:0] pick_size();
    int unsigned k;
    int unsigned pb;
    pb = pb_reg;
    k = $urandom_range(0, 99);
    if (k < 8) return 16'($urandom);
    if (k < 16) return 16'(pb + $urandom_range(0, 2));
    if (k < 26) return (pb > 3) ? 16'(pb - $urandom_range(0, 3)) : 16'(pb);
    return 16'($urandom_range(0, pb / 8));
  endfunction

  function automatic logic [3:0] pick_align();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return 4'($urandom_range(0, 3));
    if (k < 90) return 4'($urandom_range(4, 12));
    return 4'($urandom_range(13, 15));
  endfunction

  // Build a random word, mostly consistent with the blocks handed out so far.
  function automatic arena_req_t make_req();
    arena_req_t r;
    int unsigned k;
    int unsigned j;
    r.mode  = MODE_ALLOC;
    r.size  = pick_size();
    r.align = pick_align();
    r.addr  = 20'($urandom);
    r.oldv  = 1'($urandom_range(0, 1));
    r.olds  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : pick_size();
    k = $urandom_range(0, 99);
    j = $urandom_range(0, 99);
    if (k < 8) begin
      r.mode = mode_t'($urandom_range(0, 3));
    end else if (k < 50) begin
      r.mode = MODE_ALLOC;
    end else if (k < 74) begin
      r.mode = MODE_REALLOC;
      if (j < 55 && last_ok) begin
        r.oldv = 1'b1;
        r.addr = last_addr;
      end else if (j < 75 && granted_q.size() > 0) begin
        r.oldv = 1'b1;
        r.addr = granted_q[$urandom_range(0, granted_q.size() - 1)];
      end
    end else if (k < 79) begin
      r.mode = MODE_RESET_ALL;
    end else begin
      r.mode = MODE_RESET_MARK;
      if (j < 45 && granted_q.size() > 0)
        r.addr = granted_q[$urandom_range(0, granted_q.size() - 1)];
      else if (j < 70)
        r.addr = {4'($urandom_range(0, cur_pg)), pb_reg};
      else if (j < 80)
        r.addr = {4'($urandom_range(0, cur_pg)), 16'(pb_reg + 16'd1)};
    end
    return r;
  endfunction

  // Offer one word, wait for its handshake, then log the result it must produce.
  task automatic issue(input arena_req_t r, input bit typed, input arena_rsp_t typed_rsp);
    arena_rsp_t pred;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= r.mode;
    req_ch.request_size <= r.size;
    req_ch.align_log2   <= r.align;
    req_ch.address      <= r.addr;
    req_ch.old_valid    <= r.oldv;
    req_ch.old_size     <= r.olds;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pred = arena_step(r);
    rsp_q.push_back(typed ? typed_rsp : pred);
    if (pred.status == ST_OK && (r.mode == MODE_ALLOC || r.mode == MODE_REALLOC)) begin
      granted_q.push_back(pred.baddr);
      if (granted_q.size() > HIST_DEPTH) void'(granted_q.pop_front());
    end
  endtask

  task automatic wait_drain();
    while (rsp_q.size() != 0) @(posedge clk);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Request side: reset, directed rows, then random phases under several page sizes.
  initial begin : stim
    int i;
    int ph;
    int n;
    logic [15:0] pb_next;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= '0;
    req_ch.request_size <= '0;
    req_ch.align_log2   <= '0;
    req_ch.address      <= '0;
    req_ch.old_valid    <= 1'b0;
    req_ch.old_size     <= '0;
    for (i = 0; i < MAX_PAGES; i++) arena_fill[i] = '0;
    open_cnt  = '0;
    cur_pg    = '0;
    last_addr = '0;
    last_ok   = 1'b0;
    pb_reg    = PAGE_BYTES_RESET;
    err_cnt   = 0;
    hold_req  = 1'b0;
    quiet     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) begin
      repeat (dir_tab[i].reps) issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
    end
    req_ch.valid <= 1'b0;

    for (ph = 0; ph < PHASE_N; ph++) begin
      // The page size register is only written with the block idle.
      wait_drain();
      pb_next = (ph == RAND_PHASE) ? 16'($urandom_range(1, 65535)) : PHASE_PB[ph];
      cfg_we    <= 1'b1;
      cfg_wdata <= pb_next;
      pb_reg = pb_next;
      @(posedge clk);
      cfg_we <= 1'b0;
      if (ph == PRESS_PHASE) hold_req = 1'b1;
      if (ph == PHASE_N - 1) quiet = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) issue(make_req(), 1'b0, '0);
      req_ch.valid <= 1'b0;
    end

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off, and the field check.
  initial begin : rsp_sink
    int unsigned hold;
    logic ready_nx;
    arena_rsp_t want;
    arena_rsp_t got;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.status = status_t'(rsp_ch.status);
        got.baddr  = rsp_ch.block_address;
        got.copy   = rsp_ch.copy_needed;
        got.cbytes = rsp_ch.copy_bytes;
        got.used   = rsp_ch.pages_used;
        if (rsp_q.size() == 0) begin
          $display("%0t: result word with none expected, got status %0d address %h",
                   $time, got.status, got.baddr);
          err_cnt++;
        end else begin
          want = rsp_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            err_cnt++;
          end
          if (got.baddr !== want.baddr) begin
            $display("%0t: block_address expected %h, got %h", $time, want.baddr, got.baddr);
            err_cnt++;
          end
          if (got.copy !== want.copy) begin
            $display("%0t: copy_needed expected %0d, got %0d", $time, want.copy, got.copy);
            err_cnt++;
          end
          if (got.cbytes !== want.cbytes) begin
            $display("%0t: copy_bytes expected %0d, got %0d", $time, want.cbytes, got.cbytes);
            err_cnt++;
          end
          if (got.used !== want.used) begin
            $display("%0t: pages_used expected %0d, got %0d", $time, want.used, got.used);
            err_cnt++;
          end
        end
      end

      // Decide ready for the next cycle.
      if (hold_req) begin
        hold = PRESS_HOLD;
        hold_req = 1'b0;
      end
      if (rst_n !== 1'b1) begin
        ready_nx = 1'b0;
      end else if (hold > 0) begin
        hold--;
        ready_nx = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 7);
        ready_nx = 1'b0;
      end else begin
        ready_nx = 1'b1;
      end
      rsp_ch.ready <= ready_nx;
    end
  end

endmodule

`default_nettype wire
